@@ rtl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 hash engine: initial chaining
// values, round constants, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [5:0] BLK_POS_LAST = 6'd63;
	localparam logic [5:0] LEN_POS      = 6'd56;

	localparam logic [6:0] RND_20   = 7'd20;
	localparam logic [6:0] RND_40   = 7'd40;
	localparam logic [6:0] RND_60   = 7'd60;
	localparam logic [6:0] RND_LAST = 7'd79;

	localparam logic [2:0] DIGEST_WORDS = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_PUBLISH
	} state_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic feed;
		src_t src;
		logic start;
		logic round;
		logic add;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       rnd_last;
		logic       out_busy;
	} sts_t;

endpackage

@@ rtl/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1_ctrl
// Controller: sequences byte loading, padding, the 80 compression rounds,
// the chaining update and the hand-off of the digest to the output buffer.
// ----------------------------------------------------------------------------
module sha1_ctrl
	import sha1_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   byte_valid,
	input  logic   last_byte,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (byte_valid && sts.pos == BLK_POS_LAST) begin
						state_d = ST_ROUND;
						ret_d   = last_byte ? ST_MARK : ST_IDLE;
					end else if (last_byte) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				if (sts.pos == BLK_POS_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_ZERO;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (sts.pos == LEN_POS) begin
					state_d = ST_LEN;
				end else if (sts.pos == BLK_POS_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_ZERO;
				end
			end
			ST_LEN: begin
				if (sts.pos == BLK_POS_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_PUBLISH;
				end
			end
			ST_ROUND: begin
				if (sts.rnd_last) state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_PUBLISH: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.src     = SRC_IN;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.feed = in_valid && byte_valid;
				cmd.src  = SRC_IN;
			end
			ST_MARK: begin
				cmd.feed = 1'b1;
				cmd.src  = SRC_MARK;
			end
			ST_ZERO: begin
				cmd.feed = (sts.pos != LEN_POS);
				cmd.src  = SRC_ZERO;
			end
			ST_LEN: begin
				cmd.feed = 1'b1;
				cmd.src  = SRC_LEN;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
			end
			ST_PUBLISH: begin
				cmd.publish = !sts.out_busy;
			end
			default: begin
				cmd.feed = 1'b0;
			end
		endcase
		// the byte that fills the block kicks off the compression
		cmd.start = cmd.feed && (sts.pos == BLK_POS_LAST);
	end

endmodule

@@ rtl/sha1_dp.sv @@
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: byte packer, 16-word schedule shift line, one SHA-1 round per
// cycle, chaining registers, message length counter and digest out buffer.
// ----------------------------------------------------------------------------
module sha1_dp
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	logic [5:0]  pos_q;
	logic [63:0] byte_count_q;
	logic [6:0]  rnd_q;
	logic [31:0] chain_q [5];
	logic [2:0]  out_cnt_q;
	logic [31:0] dig_q [5];
	logic [23:0] word_q;
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic [7:0]  feed_byte;
	logic [63:0] len_bits;
	logic [63:0] len_sh;
	logic [31:0] f_val, k_val, t_val, w_new;
	logic        out_take;

	assign len_bits = {byte_count_q[60:0], 3'b000};
	assign len_sh   = len_bits << {pos_q[2:0], 3'b000};

	always_comb begin
		unique case (cmd.src)
			SRC_IN:   feed_byte = data_byte;
			SRC_MARK: feed_byte = PAD_MARK;
			SRC_ZERO: feed_byte = 8'h00;
			SRC_LEN:  feed_byte = len_sh[63:56];
			default:  feed_byte = 8'h00;
		endcase
	end

	always_comb begin
		priority if (rnd_q < RND_20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (rnd_q < RND_40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (rnd_q < RND_60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
	end

	assign t_val = rotl5(a_q) + f_val + e_q + k_val + w_q[0];
	assign w_new = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);

	assign out_valid   = (out_cnt_q != 3'd0);
	assign out_take    = out_valid && out_ready;
	assign digest_word = dig_q[0];
	assign word_index  = DIGEST_WORDS - out_cnt_q;
	assign last_word   = (out_cnt_q == 3'd1);

	assign sts.pos      = pos_q;
	assign sts.rnd_last = (rnd_q == RND_LAST);
	assign sts.out_busy = out_valid;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			byte_count_q <= '0;
			rnd_q        <= '0;
			out_cnt_q    <= '0;
			chain_q[0]   <= H0_INIT;
			chain_q[1]   <= H1_INIT;
			chain_q[2]   <= H2_INIT;
			chain_q[3]   <= H3_INIT;
			chain_q[4]   <= H4_INIT;
		end else begin
			if (cmd.feed) begin
				pos_q <= pos_q + 6'd1;
				if (cmd.src == SRC_IN) byte_count_q <= byte_count_q + 64'd1;
			end
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (cmd.add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.publish) begin
				// digest leaves for the out buffer, next message starts fresh
				out_cnt_q    <= DIGEST_WORDS;
				byte_count_q <= '0;
				chain_q[0]   <= H0_INIT;
				chain_q[1]   <= H1_INIT;
				chain_q[2]   <= H2_INIT;
				chain_q[3]   <= H3_INIT;
				chain_q[4]   <= H4_INIT;
			end else if (out_take) begin
				out_cnt_q <= out_cnt_q - 3'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.feed) begin
			word_q <= {word_q[15:0], feed_byte};
			if (pos_q[1:0] == 2'b11) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= {word_q, feed_byte};
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= rotl30(b_q);
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.publish) begin
			for (int i = 0; i < 5; i++) dig_q[i] <= chain_q[i];
		end else if (out_take) begin
			for (int i = 0; i < 4; i++) dig_q[i] <= dig_q[i + 1];
			dig_q[4] <= dig_q[4];
		end
	end

endmodule

@@ rtl/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 digest of a byte stream, one message byte per input item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): data_byte with byte_valid and last_byte.
// An item with byte_valid set appends its byte; last_byte ends the message
// (byte_valid low with last_byte high ends it without a byte, e.g. an empty
// message). An item with both flags low is dropped.
// Bytes are taken one per cycle while in_ready is high; the byte that completes
// a 64-byte block starts the 80 rounds of the single round unit and then the
// chaining add, during which no input is taken.
// At the end of a message, padding and length are fed one byte per cycle
// through the same packer, with one or two compressions, set by how full the
// last block was; the digest then passes to the output buffer.
// The five digest words then leave h0 first on the output channel
// (out_valid/out_ready) with word_index and last_word, one per cycle while out_ready is high.
// in_ready drops while a block compresses or padding runs, and also while a
// finished digest waits for the previous one to drain, so a stalled receiver
// backs up into the input once the output buffer is full.
// Reset restores the initial chaining values and clears the length count.
// ----------------------------------------------------------------------------
module sha1_hash_engine
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	cmd_t cmd;
	sts_t sts;

	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.byte_valid (byte_valid),
		.last_byte  (last_byte),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
